/* rtl/arp_address_cache_defines.svh */
// Assertion macros for the checker file of the address cache.
`ifndef ARP_ADDRESS_CACHE_DEFINES_SVH
`define ARP_ADDRESS_CACHE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ARPAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ARPAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/arpac_pkg.sv */
// Types, widths and codes shared by the address cache modules.
package arpac_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int STATUS_W    = 3;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

endpackage

/* rtl/arpac_if.sv */
// Request and response channel interfaces of the address cache.
interface arpac_in_if;
    import arpac_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;

    modport source (output valid, output action, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input action, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface arpac_out_if;
    import arpac_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    found_mac;

    modport source (output valid, output status, output found_mac, input ready);
    modport sink   (input valid, input status, input found_mac, output ready);
endinterface

/* rtl/arpac_table.sv */
// Entry store of the address cache: one write port, one registered read port.
module arpac_table #(
    parameter int  ENTRIES = arpac_pkg::ENTRIES_DEF,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  arpac_pkg::t_entry i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output arpac_pkg::t_entry o_rd_data
);
    import arpac_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    // Write the new pair and register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/arpac_ctrl.sv */
// Scan sequencer of the address cache with its shared address comparator.
module arpac_ctrl #(
    parameter int  ENTRIES = arpac_pkg::ENTRIES_DEF,
    localparam int IDX_W   = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    arpac_in_if.sink          i_req,
    arpac_out_if.source       o_rsp,
    output logic              o_wr_en,
    output logic [IDX_W-1:0]  o_wr_addr,
    output arpac_pkg::t_entry o_wr_data,
    output logic [IDX_W-1:0]  o_rd_addr,
    input  arpac_pkg::t_entry i_rd_data
);
    import arpac_pkg::*;

    localparam int               CNT_W    = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_fill,  n_fill;
    logic [CNT_W-1:0]    r_idx,   n_idx;
    logic                r_pend,  n_pend;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [MAC_W-1:0]    r_found,  n_found;
    logic                r_act;
    logic [IP_W-1:0]     r_ip;
    logic [MAC_W-1:0]    r_mac;

    logic w_accept;
    logic w_match;
    logic w_more;

    assign w_accept = i_req.valid && i_req.ready;

    // Shared comparator: word read last cycle against the requested address
    assign w_match = r_pend && (i_rd_data.ip == r_ip);
    assign w_more  = (r_idx < r_fill);

    // Sequence the scan, one stored entry per cycle
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_status = r_status;
        n_found  = r_found;
        o_wr_en  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_status = (r_act == ACT_INSERT) ? ST_PRESENT : ST_HIT;
                    n_found  = i_rd_data.mac;
                    n_pend   = 1'b0;
                    n_state  = S_OUT;
                end else if (w_more) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_found = '0;
                    n_pend  = 1'b0;
                    n_state = S_OUT;
                    if (r_act == ACT_LOOKUP) begin
                        n_status = ST_MISS;
                    end else if (r_fill >= FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        o_wr_en  = 1'b1;
                        n_fill   = r_fill + 1'b1;
                        n_status = ST_INSERTED;
                    end
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // Hold the request beat and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_req.action;
            r_ip  <= i_req.ip_addr;
            r_mac <= i_req.mac_addr;
        end
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_rd_addr      = r_idx[IDX_W-1:0];
    assign o_wr_addr      = r_fill[IDX_W-1:0];
    assign o_wr_data      = '{ip: r_ip, mac: r_mac};

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = (r_state == S_OUT);
    assign o_rsp.status    = r_status;
    assign o_rsp.found_mac = r_found;

endmodule

/* rtl/arp_address_cache.sv */
// Top level of the address cache mapping IPv4 addresses to MAC addresses.
// Use:
//   i_req carries one beat per request: action (0 look up, 1 insert),
//   ip_addr and mac_addr. o_rsp returns exactly one beat per request:
//   status (0 hit, 1 miss, 2 inserted, 3 already present, 4 full and
//   dropped) and found_mac (stored MAC on hit or already present, else 0).
//   Entries are compared oldest first through one address comparator fed
//   by a registered table read, one entry per cycle. A miss, an insert or
//   a drop gives its response beat after every stored entry is compared;
//   a hit in slot k ends the scan early, once slot k is compared.
//   i_req.ready is high only while the block is idle, so one request is
//   in flight at a time; the next request beat can follow in the cycle
//   after the response beat.
//   Reset clears the fill count, so the table is empty afterwards; stored
//   words are never cleared and are compared only once written.
//   When the receiver holds o_rsp.ready low, the response beat holds and
//   no new request is taken until it is delivered.
module arp_address_cache #(
    parameter int ENTRIES = arpac_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arpac_in_if.sink    i_req,
    arpac_out_if.source o_rsp
);
    import arpac_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_data;

    // Sequencer and comparator
    arpac_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    // Entry store
    arpac_table #(.ENTRIES(ENTRIES)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

/* rtl/arpac_checker.sv */
// Port-level checker of the address cache and its bind to the top level.
`include "arp_address_cache_defines.svh"

module arpac_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [arpac_pkg::STATUS_W-1:0] i_status,
    input logic [arpac_pkg::MAC_W-1:0]    i_found_mac
);
    import arpac_pkg::*;

    // Busy from the request beat until its response is delivered
    `ARPAC_ASSERT_NEXT(a_busy_after_req, i_in_valid && i_in_ready, !i_in_ready, "ready after request beat")
    `ARPAC_ASSERT_NOW(a_no_req_while_rsp, i_out_valid, !i_in_ready, "request taken while response waits")
    // Miss, insert and drop carry no MAC
    `ARPAC_ASSERT_NOW(a_zero_mac, i_out_valid && (i_status == ST_MISS || i_status == ST_INSERTED || i_status == ST_FULL), i_found_mac == '0, "MAC on status without match")
    // Hold a stalled response beat
    `ARPAC_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_found_mac), "stalled response changed")

endmodule

bind arp_address_cache arpac_checker u_arpac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found_mac (o_rsp.found_mac)
);

/* tb/testbench.sv */
// Self-checking testbench for the IPv4-to-MAC address cache.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arpac_pkg::*;

    localparam int CACHE_SLOTS  = ENTRIES_DEF;
    localparam int ROWS         = 20;
    localparam int RANDOM_ITEMS = 930;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 2 * CACHE_SLOTS + 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic             act;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MAC_W-1:0]    mac;
    } t_rsp;

    typedef struct packed {
        logic                act;
        logic [IP_W-1:0]     ip;
        logic [MAC_W-1:0]    mac;
        logic                typed;
        logic [STATUS_W-1:0] want_status;
        logic [MAC_W-1:0]    want_mac;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    arpac_in_if  req_ch ();
    arpac_out_if rsp_ch ();

    arp_address_cache #(
        .ENTRIES(CACHE_SLOTS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Shadow copy of the address table
    logic [IP_W-1:0]  cache_ip  [CACHE_SLOTS];
    logic [MAC_W-1:0] cache_mac [CACHE_SLOTS];
    int               cache_fill;

    t_rsp             pending_rsp [$];
    t_row             directed_rows [ROWS];
    logic             row_typed;
    t_rsp             row_want;
    t_rsp             pred_rsp;
    t_rsp             exp_rsp;
    int               errs;
    int               rsp_taken;
    int               status_seen [5];
    int               cycles;

    // Resolve one request against the shadow table and update it
    function automatic t_rsp resolve_request(input t_req req);
        t_rsp res;
        int   slot;
        slot = -1;
        for (int k = 0; k < cache_fill; k++) begin
            if (slot < 0 && cache_ip[k] == req.ip) slot = k;
        end
        res.mac = '0;
        if (req.act == ACT_LOOKUP) begin
            if (slot >= 0) begin
                res.status = ST_HIT;
                res.mac    = cache_mac[slot];
            end else begin
                res.status = ST_MISS;
            end
        end else if (slot >= 0) begin
            res.status = ST_PRESENT;
            res.mac    = cache_mac[slot];
        end else if (cache_fill >= CACHE_SLOTS) begin
            res.status = ST_FULL;
        end else begin
            cache_ip[cache_fill]  = req.ip;
            cache_mac[cache_fill] = req.mac;
            cache_fill++;
            res.status = ST_INSERTED;
        end
        return res;
    endfunction

    // Idle cycles for one beat; one stretch in five runs flat out
    function automatic int draw_wait(input int count, input int span, input int calm);
        if ((count / span) % 5 == calm) return 0;
        return $urandom_range(0, 9);
    endfunction

    // Mostly known addresses, some one bit away, the rest fresh
    function automatic t_req draw_request();
        t_req req;
        int   pick;
        pick     = $urandom_range(0, 99);
        req.act  = ($urandom_range(0, 99) < 30) ? ACT_INSERT : ACT_LOOKUP;
        req.mac  = MAC_W'({$urandom, $urandom});
        req.ip   = $urandom;
        if (cache_fill > 0 && pick < 55) begin
            req.ip = cache_ip[$urandom_range(0, cache_fill - 1)];
        end else if (cache_fill > 0 && pick < 65) begin
            req.ip = cache_ip[$urandom_range(0, cache_fill - 1)]
                     ^ (32'd1 << $urandom_range(0, 31));
        end
        return req;
    endfunction

    // Offer one request beat and hold it until taken; entered and left at a falling edge
    task automatic send_req(input t_req req, input int idx);
        int gap;
        gap = draw_wait(idx, 60, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= req.act;
        req_ch.ip_addr  <= req.ip;
        req_ch.mac_addr <= req.mac;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Predict on each request beat, check each response beat
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            pred_rsp = resolve_request('{req_ch.action, req_ch.ip_addr, req_ch.mac_addr});
            pending_rsp.push_back(row_typed ? row_want : pred_rsp);
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken++;
            if (rsp_ch.status < 5) status_seen[rsp_ch.status]++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none expected, status %0d mac %h",
                         $time, rsp_ch.status, rsp_ch.found_mac);
                errs++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, exp_rsp.status, rsp_ch.status);
                    errs++;
                end
                if (rsp_ch.found_mac !== exp_rsp.mac) begin
                    $display("%0t: found_mac expected %h, got %h",
                             $time, exp_rsp.mac, rsp_ch.found_mac);
                    errs++;
                end
            end
        end
    end

    // Response side: random stalls, one long hold-off to back up the input
    initial begin : drain
        int  stall;
        logic held;
        held         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!held && rsp_taken >= HOLD_AT) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = draw_wait(rsp_taken, 70, 2);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge i_clk);
        end
    end

    // Reset, directed rows, random traffic, then drain and report
    initial begin : stimulus
        t_req req;
        errs            = 0;
        rsp_taken       = 0;
        cycles          = 0;
        cache_fill      = 0;
        row_typed       = 1'b0;
        row_want        = '0;
        status_seen     = '{default: 0};
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_LOOKUP;
        req_ch.ip_addr  = '0;
        req_ch.mac_addr = '0;

        // empty table, extremes, duplicates, a near miss and plain traffic
        directed_rows = '{
            '{ACT_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, ST_MISS,     48'h0},
            '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_MISS,     48'h0},
            '{ACT_INSERT, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, ST_INSERTED, 48'h0},
            '{ACT_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, ST_HIT,      48'h0},
            '{ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_INSERTED, 48'h0},
            '{ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, ST_HIT,
              48'hFFFF_FFFF_FFFF},
            '{ACT_INSERT, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, ST_PRESENT,  48'h0},
            '{ACT_INSERT, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, ST_PRESENT,
              48'hFFFF_FFFF_FFFF},
            '{ACT_LOOKUP, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_MISS,     48'h0},
            '{ACT_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 1'b1, ST_INSERTED, 48'h0},
            '{ACT_INSERT, 32'hC0A8_0001, 48'h0011_2233_4455, 1'b1, ST_INSERTED, 48'h0},
            '{ACT_LOOKUP, 32'hC0A8_0001, 48'h0000_0000_0000, 1'b1, ST_HIT,
              48'h0011_2233_4455},
            '{ACT_LOOKUP, 32'hC0A8_0000, 48'h0000_0000_0000, 1'b1, ST_MISS,     48'h0},
            '{ACT_INSERT, 32'h8000_0000, 48'h0000_0000_0001, 1'b1, ST_PRESENT,
              48'h8000_0000_0000},
            '{ACT_LOOKUP, 32'h8000_0000, 48'h0000_0000_0000, 1'b1, ST_HIT,
              48'h8000_0000_0000},
            '{ACT_INSERT, 32'h0000_0001, 48'h0000_0000_0001, 1'b1, ST_INSERTED, 48'h0},
            '{ACT_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000, 1'b1, ST_HIT,      48'h1},
            '{ACT_LOOKUP, 32'hFFFF_FFFE, 48'h5555_5555_5555, 1'b0, ST_MISS,     48'h0},
            '{ACT_INSERT, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0, ST_MISS,     48'h0},
            '{ACT_LOOKUP, 32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b0, ST_MISS,     48'h0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed rows
        for (int k = 0; k < ROWS; k++) begin
            row_typed = directed_rows[k].typed;
            row_want  = '{directed_rows[k].want_status, directed_rows[k].want_mac};
            send_req('{directed_rows[k].act, directed_rows[k].ip, directed_rows[k].mac}, k);
        end
        row_typed = 1'b0;

        // random traffic checked against the shadow table
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            req = draw_request();
            send_req(req, ROWS + k);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests; table ended with %0d of %0d slots filled.",
                 ROWS + RANDOM_ITEMS, cache_fill, CACHE_SLOTS);
        $display("Responses: %0d hit, %0d miss, %0d inserted, %0d present, %0d dropped.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errs == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
